[hw/rtl/sha1he_pkg.sv]
// Shared types, constants and helpers for the SHA-1 hash engine.
package sha1he_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned NUM_CHAIN   = 5;
	localparam int unsigned NUM_SCHED   = 16;
	localparam int unsigned BLOCK_BYTES = 64;

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [5:0] LAST_FILL  = 6'd63;
	localparam logic [5:0] LEN_POS    = 6'd55;
	localparam logic [2:0] LAST_INDEX = 3'd4;

	localparam logic       CMD_ABSORB = 1'b0;
	localparam logic       CMD_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam word_t K_0 = 32'h5a827999;
	localparam word_t K_1 = 32'h6ed9eba1;
	localparam word_t K_2 = 32'h8f1bbcdc;
	localparam word_t K_3 = 32'hca62c1d6;

	localparam word_t H_INIT [NUM_CHAIN] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	function automatic word_t rotl1(input word_t v);
		return {v[30:0], v[31]};
	endfunction

	function automatic word_t rotl5(input word_t v);
		return {v[26:0], v[31:27]};
	endfunction

	function automatic word_t rotl30(input word_t v);
		return {v[1:0], v[31:2]};
	endfunction

endpackage

[hw/rtl/sha1_hash_engine_unit.sv]
// SHA-1 hash engine: byte absorb, padding, 80-round compression and digest output.
// An absorb transfer leaves the engine ready again, except the one that completes a
// 64-byte block: it is followed by a busy phase (80 rounds, one per cycle through the
// single round adder, then a fold step that adds the working words into the chaining
// words). A finish transfer starts compression of the padded block, and of a second
// block when the padding spills over (message length mod 64 above 55), after which the
// five digest words H0..H4 leave as five output transfers, the last one marked.
// in_ready is low while a block is compressed and while the digest is being sent; the
// engine then restarts with the initial chaining values for the next message.
module sha1_hash_engine_unit
	import sha1he_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROUND = 3'd1;
	localparam logic [2:0] S_FOLD  = 3'd2;
	localparam logic [2:0] S_EMIT  = 3'd3;

	logic [2:0]  state_q;
	logic [6:0]  round_q;
	logic [5:0]  fill_q;
	logic [60:0] byte_cnt_q;
	logic        final_q;
	logic        need_len_q;
	logic [2:0]  idx_q;
	word_t       chain_q [NUM_CHAIN];
	word_t       sched_q [NUM_SCHED];
	word_t       work_q  [NUM_CHAIN];

	logic        in_fire;
	logic        out_fire;
	logic        start_cmp;
	logic [63:0] len_bits;
	word_t       f_val;
	word_t       k_val;
	word_t       round_sum;
	word_t       fold_sum [NUM_CHAIN];

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign start_cmp = in_fire && ((command == CMD_FINISH) || (fill_q == LAST_FILL));
	assign len_bits  = {byte_cnt_q, 3'b000};

	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == LAST_INDEX);

	always_comb begin
		if (round_q < 7'd20) begin
			f_val = (work_q[1] & work_q[2]) ^ (~work_q[1] & work_q[3]);
			k_val = K_0;
		end else if (round_q < 7'd40) begin
			f_val = work_q[1] ^ work_q[2] ^ work_q[3];
			k_val = K_1;
		end else if (round_q < 7'd60) begin
			f_val = (work_q[1] & work_q[2]) ^ (work_q[1] & work_q[3])
				^ (work_q[2] & work_q[3]);
			k_val = K_2;
		end else begin
			f_val = work_q[1] ^ work_q[2] ^ work_q[3];
			k_val = K_3;
		end
		round_sum = rotl5(work_q[0]) + f_val + work_q[4] + k_val + sched_q[0];
		for (int i = 0; i < NUM_CHAIN; i++) begin
			fold_sum[i] = chain_q[i] + work_q[i];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (command == CMD_ABSORB) begin
						sched_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= data_byte;
					end else begin
						for (int j = 0; j < BLOCK_BYTES; j++) begin
							if (6'(j) == fill_q) begin
								sched_q[j/4][8*(3-(j%4)) +: 8] <= PAD_BYTE;
							end else if ((6'(j) > fill_q)
								&& ((6'(j) <= LEN_POS) || (fill_q > LEN_POS))) begin
								sched_q[j/4][8*(3-(j%4)) +: 8] <= 8'h00;
							end
						end
						if (fill_q <= LEN_POS) begin
							sched_q[14] <= len_bits[63:32];
							sched_q[15] <= len_bits[31:0];
						end
					end
				end
				if (start_cmp) begin
					for (int i = 0; i < NUM_CHAIN; i++) begin
						work_q[i] <= chain_q[i];
					end
				end
			end
			S_ROUND: begin
				for (int i = 0; i < NUM_SCHED - 1; i++) begin
					sched_q[i] <= sched_q[i+1];
				end
				sched_q[NUM_SCHED-1] <= rotl1(sched_q[13] ^ sched_q[8] ^ sched_q[2]
					^ sched_q[0]);
				work_q[0] <= round_sum;
				work_q[1] <= work_q[0];
				work_q[2] <= rotl30(work_q[1]);
				work_q[3] <= work_q[2];
				work_q[4] <= work_q[3];
			end
			S_FOLD: begin
				if (need_len_q) begin
					for (int i = 0; i < NUM_SCHED - 2; i++) begin
						sched_q[i] <= '0;
					end
					sched_q[14] <= len_bits[63:32];
					sched_q[15] <= len_bits[31:0];
					for (int i = 0; i < NUM_CHAIN; i++) begin
						work_q[i] <= fold_sum[i];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			round_q    <= '0;
			fill_q     <= '0;
			byte_cnt_q <= '0;
			final_q    <= 1'b0;
			need_len_q <= 1'b0;
			idx_q      <= '0;
			for (int i = 0; i < NUM_CHAIN; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						round_q <= '0;
						if (command == CMD_ABSORB) begin
							fill_q     <= fill_q + 6'd1;
							byte_cnt_q <= byte_cnt_q + 61'd1;
							final_q    <= 1'b0;
							need_len_q <= 1'b0;
							if (fill_q == LAST_FILL) begin
								state_q <= S_ROUND;
							end
						end else begin
							fill_q     <= '0;
							final_q    <= 1'b1;
							need_len_q <= (fill_q > LEN_POS);
							state_q    <= S_ROUND;
						end
					end
				end
				S_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == LAST_ROUND) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					for (int i = 0; i < NUM_CHAIN; i++) begin
						chain_q[i] <= fold_sum[i];
					end
					round_q <= '0;
					idx_q   <= '0;
					if (!final_q) begin
						state_q <= S_IDLE;
					end else if (need_len_q) begin
						need_len_q <= 1'b0;
						state_q    <= S_ROUND;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_fire) begin
						if (idx_q == LAST_INDEX) begin
							for (int i = 0; i < NUM_CHAIN; i++) begin
								chain_q[i] <= H_INIT[i];
							end
							byte_cnt_q <= '0;
							final_q    <= 1'b0;
							idx_q      <= '0;
							state_q    <= S_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_busy_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides open at once");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND) |-> (round_q <= LAST_ROUND))
		else $error("round counter past last round");

	a_full_block_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (command == CMD_ABSORB) && (fill_q == LAST_FILL)) |=> !in_ready)
		else $error("full block did not start compression");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_word) |=> (in_ready && (fill_q == '0) && (byte_cnt_q == '0)))
		else $error("engine did not restart after digest");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (word_index <= LAST_INDEX))
		else $error("digest word index out of range");

endmodule

[test/testbench.sv]
// Self-checking testbench for the SHA-1 hash engine: byte stream in, five digest words out.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1he_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned MAX_SHOWN    = 10;
	localparam int unsigned RANDOM_ITEMS = 12;
	localparam int unsigned HOLD_CYCLES  = 400;

	typedef struct packed {
		word_t      value;
		logic [2:0] index;
		logic       last;
	} digest_entry_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	word_t         chain_state [NUM_CHAIN];
	logic [7:0]    msg_block [BLOCK_BYTES];
	int unsigned   block_fill;
	logic [60:0]   msg_len_bytes;
	digest_entry_t digest_expect [$];

	bit          idle_enable    = 1'b1;
	int unsigned hold_request   = 0;
	int unsigned cycle_count    = 0;
	int unsigned mismatch_count = 0;
	int unsigned digests_done   = 0;
	int unsigned bytes_done     = 0;
	int unsigned words_checked  = 0;

	sha1_hash_engine_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function void restart_digest();
		int i;
		for (i = 0; i < NUM_CHAIN; i++)
			chain_state[i] = H_INIT[i];
		block_fill = 0;
		msg_len_bytes = '0;
	endfunction

	function void compress_block();
		word_t sched [NUM_SCHED];
		word_t a, b, c, d, e, f, k, mix, cur, tmp;
		int    i, t;
		for (i = 0; i < NUM_SCHED; i++)
			sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		a = chain_state[0];
		b = chain_state[1];
		c = chain_state[2];
		d = chain_state[3];
		e = chain_state[4];
		for (t = 0; t < 80; t++) begin
			if (t >= 16) begin
				mix = sched[(t+13)%16] ^ sched[(t+8)%16] ^ sched[(t+2)%16] ^ sched[t%16];
				sched[t%16] = {mix[30:0], mix[31]};
			end
			cur = sched[t%16];
			if (t < 20) begin
				f = (b & c) ^ (~b & d);
				k = K_0;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = K_1;
			end else if (t < 60) begin
				f = (b & c) ^ (b & d) ^ (c & d);
				k = K_2;
			end else begin
				f = b ^ c ^ d;
				k = K_3;
			end
			tmp = {a[26:0], a[31:27]} + f + e + k + cur;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = tmp;
		end
		chain_state[0] += a;
		chain_state[1] += b;
		chain_state[2] += c;
		chain_state[3] += d;
		chain_state[4] += e;
	endfunction

	function void predict_transfer(logic cmd, logic [7:0] value);
		logic [63:0] bit_len;
		int          i;
		if (cmd == CMD_ABSORB) begin
			msg_block[block_fill] = value;
			block_fill++;
			msg_len_bytes++;
			bytes_done++;
			if (block_fill == BLOCK_BYTES) begin
				compress_block();
				block_fill = 0;
			end
		end else begin
			msg_block[block_fill] = PAD_BYTE;
			for (i = block_fill + 1; i < BLOCK_BYTES; i++)
				msg_block[i] = 8'h00;
			if (block_fill > LEN_POS) begin
				compress_block();
				for (i = 0; i < BLOCK_BYTES; i++)
					msg_block[i] = 8'h00;
			end
			bit_len = {msg_len_bytes, 3'b000};
			for (i = 0; i < 8; i++)
				msg_block[BLOCK_BYTES - 8 + i] = bit_len[63 - 8*i -: 8];
			compress_block();
			for (i = 0; i < NUM_CHAIN; i++)
				digest_expect.push_back(digest_entry_t'{chain_state[i], 3'(i),
					(i == NUM_CHAIN - 1)});
			digests_done++;
			restart_digest();
		end
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_SHOWN)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	task automatic send_item(input logic cmd, input logic [7:0] value);
		int unsigned gap;
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		data_byte <= value;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		predict_transfer(cmd, value);
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_message(input int unsigned len);
		int unsigned i;
		for (i = 0; i < len; i++)
			send_item(CMD_ABSORB, 8'($urandom_range(0, 255)));
		send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_directed();
		int i;
		send_item(CMD_FINISH, 8'h00);
		send_item(CMD_FINISH, 8'hff);
		send_item(CMD_ABSORB, 8'h61);
		send_item(CMD_ABSORB, 8'h62);
		send_item(CMD_ABSORB, 8'h63);
		send_item(CMD_FINISH, 8'h00);
		send_item(CMD_ABSORB, 8'h00);
		send_item(CMD_ABSORB, 8'hff);
		send_item(CMD_FINISH, 8'h55);
		for (i = 0; i < 8; i++)
			send_item(CMD_ABSORB, i[0] ? 8'h5a : 8'ha5);
		send_item(CMD_FINISH, 8'haa);
		release_input();
	endtask

	task automatic test_block_boundaries();
		send_message(LEN_POS);
		send_message(LEN_POS + 1);
		release_input();
	endtask

	task automatic test_output_hold();
		int i;
		hold_request = HOLD_CYCLES;
		for (i = 0; i < 3; i++)
			send_message($urandom_range(0, 3));
		release_input();
	endtask

	task automatic test_random_messages();
		int unsigned sent, messages, len;
		sent = 0;
		messages = 0;
		while (sent < RANDOM_ITEMS || messages < 2) begin
			len = $urandom_range(0, 12);
			send_message(len);
			sent += len + 1;
			messages++;
		end
		release_input();
	endtask

	task automatic test_full_rate();
		idle_enable = 1'b0;
		send_message(BLOCK_BYTES);
		send_message(0);
		release_input();
	endtask

	initial begin
		int unsigned stall_left;
		out_ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (hold_request > 0) begin
				out_ready <= 1'b0;
				stall_left = hold_request - 1;
				hold_request = 0;
			end else if (idle_enable && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 13);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		digest_entry_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && out_ready) begin
				words_checked++;
				if (digest_expect.size() == 0) begin
					note_mismatch("unexpected digest word", '0, digest_word);
				end else begin
					want = digest_expect.pop_front();
					if (digest_word !== want.value)
						note_mismatch("digest_word", want.value, digest_word);
					if (word_index !== want.index)
						note_mismatch("word_index", want.index, word_index);
					if (last_word !== want.last)
						note_mismatch("last_word", want.last, last_word);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_ABSORB;
		data_byte <= 8'h00;
		restart_digest();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_block_boundaries();
		test_output_hold();
		test_random_messages();
		test_full_rate();
		while (digest_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d digests (%0d words) over %0d message bytes",
			digests_done, words_checked, bytes_done);
		$display("covered empty messages, padding at block edges and a long output stall");
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/sha1he_pkg.sv
hw/rtl/sha1_hash_engine_unit.sv
test/testbench.sv
